// ===== rtl/equirect_to_cubemap_coords_top_macros.svh =====
// Assertion macros shared by the coordinate mapper RTL.
`ifndef EQUIRECT_TO_CUBEMAP_COORDS_TOP_MACROS_SVH
`define EQUIRECT_TO_CUBEMAP_COORDS_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/e2c_pkg.sv =====
// Shared constants, types and the arctangent table of the coordinate mapper.
`default_nettype none
package e2c_pkg;

   localparam int ANGLE_BITS    = 20;
   localparam int CORDIC_STEPS  = 20;
   localparam int MAX_SIDE      = 4096;
   localparam int MAX_SRC_WIDTH = 8192;
   localparam int SRC_Y_LIMIT   = 4095;
   localparam int VEC_FRAC      = 16;

   localparam int DIFF_W = 13;                      // signed face offsets
   localparam int SUM_W  = 25;                      // sum of two squares
   localparam int RAD_W  = SUM_W + 2 * VEC_FRAC;    // radicand
   localparam int ROOT_W = 29;                      // hypotenuse, 16 fraction bits
   localparam int VEC_W  = 32;                      // CORDIC vector parts
   localparam int Z_W    = ANGLE_BITS + 2;          // signed angle accumulator
   localparam int LANES  = 2;                       // azimuth and elevation
   localparam int LANE_AZ = 0;
   localparam int LANE_EL = 1;

   typedef enum logic [1:0] {
      CSR_FACE_SIDE  = 2'd0,
      CSR_SRC_WIDTH  = 2'd1,
      CSR_SRC_HEIGHT = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      FACE_BACK  = 3'd0,
      FACE_RIGHT = 3'd1,
      FACE_UP    = 3'd2,
      FACE_FRONT = 3'd3,
      FACE_DOWN  = 3'd4,
      FACE_LEFT  = 3'd5
   } face_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] ay;
      logic signed [DIFF_W-1:0] ax;
      logic signed [DIFF_W-1:0] ey;
   } side_type;

   localparam logic [31:0] MICRO_ANGLE32 [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   // Micro-angle of step i, rounded half up to ANGLE_BITS bits per turn.
   function automatic logic [ANGLE_BITS-1:0] micro_angle(input int i);
      logic [32:0] t;
      t = {1'b0, MICRO_ANGLE32[i]};
      if (ANGLE_BITS < 32) begin
         t = ((t >> (32 - ANGLE_BITS - 1)) + 33'd1) >> 1;
      end
      return t[ANGLE_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/e2c_sqrt.sv =====
// Pipelined integer square root of (a*a + b*b) << 32, one root bit per stage.
`default_nettype none
module e2c_sqrt (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 en,
   input  wire logic                                 in_valid,
   input  wire logic signed [e2c_pkg::DIFF_W-1:0]    op_a,
   input  wire logic signed [e2c_pkg::DIFF_W-1:0]    op_b,
   input  wire e2c_pkg::side_type                    in_side,
   output logic                                      out_valid,
   output logic [e2c_pkg::ROOT_W-1:0]                out_root,
   output e2c_pkg::side_type                         out_side
);
   localparam int RW = e2c_pkg::ROOT_W;
   localparam int NW = e2c_pkg::RAD_W;

   logic                 valid_ff [RW+1];
   logic [NW-1:0]        rem_ff   [RW+1];
   logic [RW-1:0]        root_ff  [RW+1];
   e2c_pkg::side_type    side_ff  [RW+1];

   logic signed [2*e2c_pkg::DIFF_W-1:0] sqa;
   logic signed [2*e2c_pkg::DIFF_W-1:0] sqb;
   logic [e2c_pkg::SUM_W-1:0]           sum_in;

   assign sqa    = op_a * op_a;
   assign sqb    = op_b * op_b;
   assign sum_in = e2c_pkg::SUM_W'(sqa[e2c_pkg::SUM_W-2:0])
                 + e2c_pkg::SUM_W'(sqb[e2c_pkg::SUM_W-2:0]);

   // Stage zero forms the radicand.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         rem_ff[0]  <= {sum_in, {(2*e2c_pkg::VEC_FRAC){1'b0}}};
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar j = 1; j <= RW; j++) begin : g_bit
      localparam int K = RW - j;
      logic [NW-1:0] trial;
      // The partial root has no bits at or below K, so the add is an OR.
      assign trial = ({{(NW-RW){1'b0}}, root_ff[j-1]} << (K + 1))
                   | (NW'(1) << (2 * K));
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (en) begin
            valid_ff[j] <= valid_ff[j-1];
         end
         if (en) begin
            side_ff[j] <= side_ff[j-1];
            if (rem_ff[j-1] >= trial) begin
               rem_ff[j]  <= rem_ff[j-1] - trial;
               root_ff[j] <= root_ff[j-1] | (RW'(1) << K);
            end else begin
               rem_ff[j]  <= rem_ff[j-1];
               root_ff[j] <= root_ff[j-1];
            end
         end
      end
   end

   assign out_valid = valid_ff[RW];
   assign out_root  = root_ff[RW];
   assign out_side  = side_ff[RW];
endmodule
`default_nettype wire

// ===== rtl/e2c_cordic.sv =====
// Two-lane pipelined vectoring CORDIC giving atan2 as a fraction of a turn.
`default_nettype none
module e2c_cordic (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               en,
   input  wire logic                               in_valid,
   input  wire logic signed [e2c_pkg::VEC_W-1:0]   y_in  [e2c_pkg::LANES],
   input  wire logic signed [e2c_pkg::VEC_W-1:0]   x_in  [e2c_pkg::LANES],
   output logic                                    out_valid,
   output logic signed [e2c_pkg::Z_W-1:0]          z_out [e2c_pkg::LANES]
);
   localparam int N  = e2c_pkg::CORDIC_STEPS;
   localparam int VW = e2c_pkg::VEC_W;
   localparam int ZW = e2c_pkg::Z_W;
   localparam logic signed [ZW-1:0] QUARTER = ZW'(1) << (e2c_pkg::ANGLE_BITS - 2);

   logic                  valid_ff [N+1];
   logic signed [VW-1:0]  x_ff     [e2c_pkg::LANES][N+1];
   logic signed [VW-1:0]  y_ff     [e2c_pkg::LANES][N+1];
   logic signed [ZW-1:0]  z_ff     [e2c_pkg::LANES][N+1];
   logic                  spec_ff  [e2c_pkg::LANES][N+1];
   logic signed [ZW-1:0]  specz_ff [e2c_pkg::LANES][N+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   for (genvar i = 1; i <= N; i++) begin : g_valid
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   for (genvar l = 0; l < e2c_pkg::LANES; l++) begin : g_lane
      // Axis-aligned vectors bypass the iterations; a left-half vector is
      // first turned by a quarter.
      always_ff @(posedge clock) begin
         if (en) begin
            spec_ff[l][0] <= (y_in[l] == '0) || (x_in[l] == '0);
            if (y_in[l] == '0) begin
               specz_ff[l][0] <= x_in[l][VW-1] ? (QUARTER <<< 1) : '0;
            end else begin
               specz_ff[l][0] <= y_in[l][VW-1] ? -QUARTER : QUARTER;
            end
            if (x_in[l][VW-1]) begin
               if (!y_in[l][VW-1]) begin
                  x_ff[l][0] <= y_in[l];
                  y_ff[l][0] <= -x_in[l];
                  z_ff[l][0] <= QUARTER;
               end else begin
                  x_ff[l][0] <= -y_in[l];
                  y_ff[l][0] <= x_in[l];
                  z_ff[l][0] <= -QUARTER;
               end
            end else begin
               x_ff[l][0] <= x_in[l];
               y_ff[l][0] <= y_in[l];
               z_ff[l][0] <= '0;
            end
         end
      end

      for (genvar i = 1; i <= N; i++) begin : g_step
         localparam logic signed [ZW-1:0] ANG =
            $signed({2'b00, e2c_pkg::micro_angle(i - 1)});
         logic signed [VW-1:0] sx;
         logic signed [VW-1:0] sy;
         assign sx = y_ff[l][i-1] >>> (i - 1);
         assign sy = x_ff[l][i-1] >>> (i - 1);
         always_ff @(posedge clock) begin
            if (en) begin
               spec_ff[l][i]  <= spec_ff[l][i-1];
               specz_ff[l][i] <= specz_ff[l][i-1];
               if (!y_ff[l][i-1][VW-1]) begin
                  x_ff[l][i] <= x_ff[l][i-1] + sx;
                  y_ff[l][i] <= y_ff[l][i-1] - sy;
                  z_ff[l][i] <= z_ff[l][i-1] + ANG;
               end else begin
                  x_ff[l][i] <= x_ff[l][i-1] - sx;
                  y_ff[l][i] <= y_ff[l][i-1] + sy;
                  z_ff[l][i] <= z_ff[l][i-1] - ANG;
               end
            end
         end
      end

      assign z_out[l] = spec_ff[l][N] ? specz_ff[l][N] : z_ff[l][N];
   end

   assign out_valid = valid_ff[N];
endmodule
`default_nettype wire

// ===== rtl/equirect_to_cubemap_coords_top.sv =====
// Top level of the cube-face to equirectangular source coordinate mapper.
`default_nettype none
`include "equirect_to_cubemap_coords_top_macros.svh"
// Takes one face pixel per clock and returns one source coordinate per clock
// while req_stall and rsp_stall are low. An input transfer reaches the rsp_
// port through a register that forms the face vectors, the squaring and the
// bit-per-stage square root of the hypotenuse, the two-lane CORDIC that finds
// azimuth and elevation together, registers for wrapping, clamping and
// scaling by the source size, and the output register. While a result is
// held the pipeline keeps moving, and taking transfers, until the next
// finished item lands in a one-entry skid stage behind it; req_stall then
// stays high until the held result is taken. Registers may be written only
// while no transfer is in flight.
module equirect_to_cubemap_coords_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [13:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_face_index,
   input  wire logic [11:0] req_pixel_x,
   input  wire logic [11:0] req_pixel_y,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [12:0]      rsp_src_x,
   output logic [11:0]      rsp_src_y
);
   localparam int DW = e2c_pkg::DIFF_W;
   localparam int AB = e2c_pkg::ANGLE_BITS;
   localparam int ZW = e2c_pkg::Z_W;
   localparam logic signed [ZW-1:0] QUARTER = ZW'(1) << (AB - 2);

   // Configuration registers.
   logic [12:0] face_side_ff;
   logic [13:0] src_width_ff;
   logic [12:0] src_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_side_ff  <= 13'd512;
         src_width_ff  <= 14'd2048;
         src_height_ff <= 13'd1024;
      end else if (csr_wr_en) begin
         case (e2c_pkg::csr_index_type'(csr_index))
            e2c_pkg::CSR_FACE_SIDE:  face_side_ff  <= csr_wdata[12:0];
            e2c_pkg::CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata;
            e2c_pkg::CSR_SRC_HEIGHT: src_height_ff <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   logic en;
   logic skid_valid_ff;
   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // Face vectors.
   logic [12:0]               side_c;
   logic [11:0]               half;
   logic signed [DW-1:0]      half_s, dx, dy;
   e2c_pkg::side_type         vec_in;
   logic signed [DW-1:0]      ha_in, hb_in;

   assign side_c = (face_side_ff > 13'(e2c_pkg::MAX_SIDE)) ?
                   13'(e2c_pkg::MAX_SIDE) : face_side_ff;
   assign half   = side_c[12:1];
   assign half_s = $signed({1'b0, half});
   assign dx     = half_s - $signed({1'b0, req_pixel_x});
   assign dy     = half_s - $signed({1'b0, req_pixel_y});

   always_comb begin
      vec_in.ey = dy;
      ha_in     = half_s;
      hb_in     = dx;
      case (req_face_index)
         e2c_pkg::FACE_RIGHT: begin
            vec_in.ay = half_s;
            vec_in.ax = -dx;
         end
         e2c_pkg::FACE_UP: begin
            vec_in.ay = -dx;
            vec_in.ax = dy;
            vec_in.ey = half_s;
            ha_in     = dx;
            hb_in     = dy;
         end
         e2c_pkg::FACE_FRONT: begin
            vec_in.ay = -dx;
            vec_in.ax = -half_s;
         end
         e2c_pkg::FACE_DOWN: begin
            vec_in.ay = -dx;
            vec_in.ax = -dy;
            vec_in.ey = -half_s;
            ha_in     = dx;
            hb_in     = dy;
         end
         e2c_pkg::FACE_LEFT: begin
            vec_in.ay = -half_s;
            vec_in.ax = dx;
         end
         default: begin
            vec_in.ay = dx;
            vec_in.ax = half_s;
         end
      endcase
   end

   logic                 st0_valid_ff;
   e2c_pkg::side_type    st0_vec_ff;
   logic signed [DW-1:0] st0_ha_ff, st0_hb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st0_valid_ff <= 1'b0;
      end else if (en) begin
         st0_valid_ff <= req_valid;
      end
      if (en) begin
         st0_vec_ff <= vec_in;
         st0_ha_ff  <= ha_in;
         st0_hb_ff  <= hb_in;
      end
   end

   logic                          sq_valid;
   logic [e2c_pkg::ROOT_W-1:0]    sq_root;
   e2c_pkg::side_type             sq_vec;

   e2c_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (st0_valid_ff),
      .op_a      (st0_ha_ff),
      .op_b      (st0_hb_ff),
      .in_side   (st0_vec_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_vec)
   );

   logic signed [e2c_pkg::VEC_W-1:0] cy [e2c_pkg::LANES];
   logic signed [e2c_pkg::VEC_W-1:0] cx [e2c_pkg::LANES];
   logic signed [ZW-1:0]             cz [e2c_pkg::LANES];
   logic                             c_valid;

   assign cy[e2c_pkg::LANE_AZ] = {{(e2c_pkg::VEC_W-DW-e2c_pkg::VEC_FRAC){sq_vec.ay[DW-1]}},
                                  sq_vec.ay, {e2c_pkg::VEC_FRAC{1'b0}}};
   assign cx[e2c_pkg::LANE_AZ] = {{(e2c_pkg::VEC_W-DW-e2c_pkg::VEC_FRAC){sq_vec.ax[DW-1]}},
                                  sq_vec.ax, {e2c_pkg::VEC_FRAC{1'b0}}};
   assign cy[e2c_pkg::LANE_EL] = {{(e2c_pkg::VEC_W-DW-e2c_pkg::VEC_FRAC){sq_vec.ey[DW-1]}},
                                  sq_vec.ey, {e2c_pkg::VEC_FRAC{1'b0}}};
   assign cx[e2c_pkg::LANE_EL] = {{(e2c_pkg::VEC_W-e2c_pkg::ROOT_W){1'b0}}, sq_root};

   e2c_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .y_in      (cy),
      .x_in      (cx),
      .out_valid (c_valid),
      .z_out     (cz)
   );

   // Wrap the azimuth, clamp the elevation.
   logic              p1_valid_ff;
   logic [AB:0]       p1_rev_ff;
   logic signed [AB-1:0] p1_el_ff;
   logic signed [ZW-1:0] el_z;

   assign el_z = cz[e2c_pkg::LANE_EL];

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= c_valid;
      end
      if (en) begin
         p1_rev_ff <= ((AB + 1)'(1) << AB) - {1'b0, cz[e2c_pkg::LANE_AZ][AB-1:0]};
         if (el_z > QUARTER) begin
            p1_el_ff <= QUARTER[AB-1:0];
         end else if (el_z < -QUARTER) begin
            p1_el_ff <= AB'(-QUARTER);
         end else begin
            p1_el_ff <= el_z[AB-1:0];
         end
      end
   end

   // Scale by the source size.
   logic                  p2_valid_ff;
   logic [AB+14:0]        p2_px_ff;
   logic signed [AB+13:0] p2_py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (en) begin
         p2_valid_ff <= p1_valid_ff;
      end
      if (en) begin
         p2_px_ff <= src_width_ff * p1_rev_ff;
         p2_py_ff <= p1_el_ff * $signed({1'b0, src_height_ff});
      end
   end

   // Truncate and clamp to the source image.
   logic [14:0]          sx_full;
   logic [13:0]          w_m1;
   logic [12:0]          sx_res;
   logic signed [AB+14:0] num;
   logic [15:0]          sy_full;
   logic [12:0]          h_m1;
   logic [11:0]          sy_res;

   always_comb begin
      sx_full = p2_px_ff[AB+14:AB];
      w_m1    = src_width_ff - 14'd1;
      if (w_m1 > 14'(e2c_pkg::MAX_SRC_WIDTH - 1)) begin
         w_m1 = 14'(e2c_pkg::MAX_SRC_WIDTH - 1);
      end
      if (src_width_ff == '0) begin
         sx_res = '0;
      end else if (sx_full > {1'b0, w_m1}) begin
         sx_res = w_m1[12:0];
      end else begin
         sx_res = sx_full[12:0];
      end

      num = $signed({{(AB + 15 - 12 - (AB - 1)){1'b0}}, src_height_ff[12:1],
                     {(AB - 1){1'b0}}})
          - (AB + 15)'(p2_py_ff);
      sy_full = num[AB+14] ? 16'd0 : num[AB+14:AB-1];
      h_m1    = src_height_ff - 13'd1;
      if (h_m1 > 13'(e2c_pkg::SRC_Y_LIMIT)) begin
         h_m1 = 13'(e2c_pkg::SRC_Y_LIMIT);
      end
      if (src_height_ff == '0) begin
         sy_res = '0;
      end else if (sy_full > {3'b000, h_m1}) begin
         sy_res = h_m1[11:0];
      end else begin
         sy_res = sy_full[11:0];
      end
   end

   // Output register and skid entry.
   logic        rsp_valid_ff;
   logic [12:0] rsp_src_x_ff;
   logic [11:0] rsp_src_y_ff;
   logic [12:0] skid_x_ff;
   logic [11:0] skid_y_ff;
   logic        load_out;

   assign load_out = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (load_out) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= p2_valid_ff;
         end
      end else if (p2_valid_ff && en) begin
         skid_valid_ff <= 1'b1;
      end
      if (load_out) begin
         if (skid_valid_ff) begin
            rsp_src_x_ff <= skid_x_ff;
            rsp_src_y_ff <= skid_y_ff;
         end else begin
            rsp_src_x_ff <= sx_res;
            rsp_src_y_ff <= sy_res;
         end
      end else if (en) begin
         skid_x_ff <= sx_res;
         skid_y_ff <= sy_res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_src_x = rsp_src_x_ff;
   assign rsp_src_y = rsp_src_y_ff;

   // The skid entry is only ever filled behind a held result.
   `ASSERT_IMPLIES(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff)
   // A finished item arriving at a held output must land in the skid entry.
   `ASSERT_NEXT(a_skid_catches, clock, reset, rsp_valid_ff && rsp_stall && p2_valid_ff && !skid_valid_ff, skid_valid_ff && rsp_valid_ff)
endmodule
`default_nettype wire
